// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for clk / rst clocked logic.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define APN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check an implication on every rising edge outside reset.
`define APN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- design/apn_pkg.sv -----
// ----------------------------------------------------------------------------
// apn_pkg
// Shared constants and types for the APN label encoder.
// ----------------------------------------------------------------------------
package apn_pkg;

  // Longest label allowed by the label length byte format
  localparam int MAX_LABEL_DEF = 63;

  // Label separator character
  localparam logic [7:0] DOT_CHAR = 8'd46;

  // Encoder sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_ERR,
    S_LEN,
    S_DATA
  } state_t;

endpackage

// ----- design/apn_ram.sv -----
// ----------------------------------------------------------------------------
// apn_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module apn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = apn_pkg::MAX_LABEL_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/apn_label_encoder.sv -----
// A label-closing item moves the sequencer to S_LEN, which loads the length byte once
//   the output slot is free; S_DATA then loads one label byte per cycle while out_ready is high.
// in_ready is high only in S_IDLE, so the input is held off while a label or an error
//   item is emitted.
// Reset (rst, synchronous): empties the label, clears discarding and out_valid.
//   The label RAM is not cleared; only entries written in the open label are read.
// ----------------------------------------------------------------------------
// apn_label_encoder
// Encodes a dotted access point name, one character per item, into
// length-prefixed labels with a single error result for a bad label.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module apn_label_encoder #(
  parameter int MAX_LABEL = apn_pkg::MAX_LABEL_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_end,
  output logic       name_end,
  output logic       error
);

  localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
  localparam int CW = $clog2(MAX_LABEL + 1);

  apn_pkg::state_t state, state_next;

  logic [CW-1:0] label_count, label_count_next;
  logic          discarding, discarding_next;
  logic          name_last;
  logic [AW-1:0] rd_addr, rd_addr_next;
  logic [7:0]    rd_data;

  logic slot_free, accept, is_dot, bad, fin;
  logic acc_err, acc_store, acc_emit, acc_drop_end;
  logic load_err, load_len, load_data;

  // Decode the incoming item
  always_comb begin
    slot_free    = !out_valid || out_ready;
    accept       = in_valid && in_ready;
    is_dot       = (ch == apn_pkg::DOT_CHAR);
    bad          = is_dot ? (is_last || (label_count == '0))
                          : (label_count >= CW'(MAX_LABEL));
    acc_err      = accept && !discarding && bad;
    acc_store    = accept && !discarding && !bad && !is_dot;
    acc_emit     = accept && !discarding && !bad && (is_dot || is_last);
    acc_drop_end = accept && discarding && is_last;
    fin          = (CW'(rd_addr) == (label_count - CW'(1)));
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = (state == apn_pkg::S_IDLE) && !rst;
    load_err  = (state == apn_pkg::S_ERR) && slot_free;
    load_len  = (state == apn_pkg::S_LEN) && slot_free;
    load_data = (state == apn_pkg::S_DATA) && slot_free;
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      apn_pkg::S_IDLE: begin
        if (acc_err) begin
          state_next = apn_pkg::S_ERR;
        end else if (acc_emit) begin
          state_next = apn_pkg::S_LEN;
        end
      end
      apn_pkg::S_ERR: begin
        if (load_err) state_next = apn_pkg::S_IDLE;
      end
      apn_pkg::S_LEN: begin
        if (load_len) state_next = apn_pkg::S_DATA;
      end
      apn_pkg::S_DATA: begin
        if (load_data && fin) state_next = apn_pkg::S_IDLE;
      end
      default: state_next = apn_pkg::S_IDLE;
    endcase
  end

  // Label count, discard flag and read pointer
  always_comb begin
    label_count_next = label_count;
    discarding_next  = discarding;
    rd_addr_next     = rd_addr;
    if (acc_err || acc_drop_end || (load_data && fin)) begin
      label_count_next = '0;
    end else if (acc_store) begin
      label_count_next = label_count + CW'(1);
    end
    if (acc_err) begin
      discarding_next = !is_last;
    end else if (acc_drop_end) begin
      discarding_next = 1'b0;
    end
    if (load_len || (load_data && fin)) begin
      rd_addr_next = '0;
    end else if (load_data) begin
      rd_addr_next = rd_addr + AW'(1);
    end
  end

  // Label buffer; the read address leads the pointer so data matches rd_addr
  apn_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LABEL)
  ) u_label_ram (
    .clk   (clk),
    .we    (acc_store),
    .waddr (AW'(label_count)),
    .wdata (ch),
    .raddr (rd_addr_next),
    .rdata (rd_data)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= apn_pkg::S_IDLE;
      label_count <= '0;
      discarding  <= 1'b0;
      rd_addr     <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      label_count <= label_count_next;
      discarding  <= discarding_next;
      rd_addr     <= rd_addr_next;
      if (load_err || load_len || load_data) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the name-end flag of the item that opened the emit
  always_ff @(posedge clk) begin
    if (acc_err || acc_emit) begin
      name_last <= is_last;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (load_err) begin
      out_byte <= 8'd0;
      run_end  <= 1'b1;
      name_end <= name_last;
      error    <= 1'b1;
    end else if (load_len) begin
      out_byte <= 8'(label_count);
      run_end  <= 1'b0;
      name_end <= 1'b0;
      error    <= 1'b0;
    end else if (load_data) begin
      out_byte <= rd_data;
      run_end  <= fin;
      name_end <= fin && name_last;
      error    <= 1'b0;
    end
  end

  // Assertions
  `APN_ASSERT(a_count_max, label_count <= CW'(MAX_LABEL), "label count above maximum")
  `APN_ASSERT_IMPL(a_err_zero, out_valid && error, out_byte == 8'd0 && run_end, "bad error item")
  `APN_ASSERT_IMPL(a_rd_range, state == apn_pkg::S_DATA, CW'(rd_addr) < label_count, "read past label")

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the APN label encoder: a short table of named cases, then random
// dotted names with long labels, broken separators and noise. Every result
// item is matched field by field against its table row or an in-bench label
// predictor, with random idle gaps on input and random stalls on output.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // One result item of the encoder
  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       name_end;
    logic       err;
  } lbl_out_t;

  // One row of the directed table; want is used only when typed is set
  typedef struct packed {
    logic [7:0] c;
    logic       last;
    logic       typed;
    lbl_out_t   want;
  } dir_row_t;

  // Pending typed expectation for one input item
  typedef struct packed {
    logic     typed;
    lbl_out_t want;
  } typed_ent_t;

  localparam lbl_out_t ERR_MID  = '{data: 8'd0, run_end: 1'b1, name_end: 1'b0, err: 1'b1};
  localparam lbl_out_t ERR_LAST = '{data: 8'd0, run_end: 1'b1, name_end: 1'b1, err: 1'b1};
  localparam lbl_out_t NO_WANT  = '0;
  localparam int       DIR_COUNT = 20;
  localparam int       RAND_ITEMS = 30;

  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{apn_pkg::DOT_CHAR, 1'b0, 1'b1, ERR_MID},    // leading dot right after reset
    '{8'h78,             1'b0, 1'b0, NO_WANT},    // skipped while discarding
    '{8'h79,             1'b1, 1'b0, NO_WANT},    // last item ends the discard
    '{8'h00,             1'b0, 1'b0, NO_WANT},    // lowest character
    '{8'hFF,             1'b0, 1'b0, NO_WANT},    // highest character
    '{apn_pkg::DOT_CHAR, 1'b0, 1'b0, NO_WANT},    // close a two-byte label
    '{apn_pkg::DOT_CHAR, 1'b0, 1'b1, ERR_MID},    // doubled dot
    '{8'h7A,             1'b1, 1'b0, NO_WANT},
    '{8'h61,             1'b0, 1'b0, NO_WANT},
    '{apn_pkg::DOT_CHAR, 1'b1, 1'b1, ERR_LAST},   // dot on the last item drops the label
    '{8'h71,             1'b1, 1'b0, NO_WANT},    // single-character name
    '{8'h80,             1'b0, 1'b0, NO_WANT},
    '{8'h7F,             1'b0, 1'b0, NO_WANT},
    '{8'h2F,             1'b0, 1'b0, NO_WANT},    // neighbors of the dot
    '{8'h2D,             1'b0, 1'b0, NO_WANT},
    '{apn_pkg::DOT_CHAR, 1'b0, 1'b0, NO_WANT},
    '{8'h55,             1'b0, 1'b0, NO_WANT},
    '{8'hAA,             1'b1, 1'b0, NO_WANT},
    '{apn_pkg::DOT_CHAR, 1'b1, 1'b1, ERR_LAST},   // lone dot as the whole name
    '{8'h6D,             1'b1, 1'b0, NO_WANT}
  };

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] ch;
  logic       is_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       name_end;
  logic       error;

  apn_label_encoder uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ch        (ch),
    .is_last   (is_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_end   (run_end),
    .name_end  (name_end),
    .error     (error)
  );

  // Predictor state
  logic [7:0] lbl_buf [apn_pkg::MAX_LABEL_DEF];
  int         lbl_len;
  bit         skip_name;
  lbl_out_t   enc_buf [apn_pkg::MAX_LABEL_DEF + 1];

  lbl_out_t   expected_bytes [$];
  typed_ent_t typed_q [$];

  int  fail_count;
  int  items_counted;
  int  results_seen;
  int  errors_seen;
  int  names_sent;
  bit  no_gaps;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop
  initial begin
    #5_000_000;
    $display("** apn_label_encoder: FAILED **");
    $finish;
  end

  // Report the error item and enter discard unless the name ends here
  function automatic int flag_error(input logic last);
    enc_buf[0] = '{data: 8'd0, run_end: 1'b1, name_end: last, err: 1'b1};
    lbl_len    = 0;
    skip_name  = !last;
    return 1;
  endfunction

  // Emit the length byte and the stored characters of the open label
  function automatic int close_label(input logic last);
    int n;
    n = lbl_len;
    enc_buf[0] = '{data: 8'(n), run_end: 1'b0, name_end: 1'b0, err: 1'b0};
    for (int i = 0; i < n; i++) begin
      enc_buf[i + 1] = '{data: lbl_buf[i], run_end: (i == n - 1),
                         name_end: (i == n - 1) && last, err: 1'b0};
    end
    lbl_len = 0;
    return n + 1;
  endfunction

  // Advance the predictor by one character; return the number of results
  function automatic int encode_char(input logic [7:0] c, input logic last);
    if (skip_name) begin
      if (last) begin
        skip_name = 1'b0;
        lbl_len   = 0;
      end
      return 0;
    end
    if (c == apn_pkg::DOT_CHAR) begin
      if (last || lbl_len == 0) return flag_error(last);
      return close_label(1'b0);
    end
    if (lbl_len >= apn_pkg::MAX_LABEL_DEF) return flag_error(last);
    lbl_buf[lbl_len] = c;
    lbl_len++;
    if (last) return close_label(1'b1);
    return 0;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [7:0] rand_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == apn_pkg::DOT_CHAR);
    return c;
  endfunction

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
      fail_count++;
    end
  endtask

  // Check result items, then predict for the accepted input item
  always @(posedge clk) begin : watch
    lbl_out_t   got;
    lbl_out_t   want;
    typed_ent_t ent;
    int         n;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{data: out_byte, run_end: run_end, name_end: name_end, err: error};
        results_seen++;
        if (got.err) errors_seen++;
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0h", $time, got);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          check_field("out_byte", want.data, got.data);
          check_field("run_end", want.run_end, got.run_end);
          check_field("name_end", want.name_end, got.name_end);
          check_field("error", want.err, got.err);
        end
      end
      if (in_valid && in_ready) begin
        ent = typed_q.pop_front();
        items_counted++;
        n = encode_char(ch, is_last);
        if (ent.typed) begin
          expected_bytes.insert(expected_bytes.size(), ent.want);
        end else begin
          for (int i = 0; i < n; i++) begin
            expected_bytes.insert(expected_bytes.size(), enc_buf[i]);
          end
        end
      end
    end
  end

  // Output stalls: random lengths, none while no_gaps is set
  initial begin
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      int stall;
      int run;
      stall = gap_len();
      run   = $urandom_range(1, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
    end
  end

  // Drive one character and hold it until the item is accepted
  task automatic send_char(input logic [7:0] c, input logic last,
                           input logic typed, input lbl_out_t want);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    typed_q.insert(typed_q.size(), '{typed: typed, want: want});
    in_valid <= 1'b1;
    ch       <= c;
    is_last  <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off the sender until every expected item has come out
  task automatic hold_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Send one dotted name; first_len forces the length of its first label
  task automatic send_name(input int first_len);
    int labels;
    int len;
    int r;
    labels = $urandom_range(1, 4);
    for (int l = 0; l < labels; l++) begin
      r = $urandom_range(0, 99);
      if (l == 0 && first_len > 0) len = first_len;
      else if (r < 3) len = apn_pkg::MAX_LABEL_DEF;
      else if (r < 5) len = apn_pkg::MAX_LABEL_DEF + 1;
      else if (r < 8) len = $urandom_range(9, apn_pkg::MAX_LABEL_DEF - 1);
      else if (r < 13) len = 0;
      else len = $urandom_range(1, 8);
      if (l == labels - 1) begin
        // final label: empty means a trailing dot on the last item
        if (len == 0) send_char(apn_pkg::DOT_CHAR, 1'b1, 1'b0, NO_WANT);
        for (int i = 0; i < len; i++) send_char(rand_char(), i == len - 1, 1'b0, NO_WANT);
      end else begin
        for (int i = 0; i < len; i++) send_char(rand_char(), 1'b0, 1'b0, NO_WANT);
        send_char(apn_pkg::DOT_CHAR, 1'b0, 1'b0, NO_WANT);
      end
    end
    names_sent++;
  endtask

  // Reset, directed table, long-label cases, random names, drain and verdict
  initial begin
    int rand_base;
    int waited;
    int k;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    ch        <= 8'd0;
    is_last   <= 1'b0;
    lbl_len   = 0;
    skip_name = 1'b0;
    no_gaps   = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (rst);

    // walk the directed table
    for (int i = 0; i < DIR_COUNT; i++) begin
      send_char(DIR_ROWS[i].c, DIR_ROWS[i].last, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end
    hold_for_drain();

    // longest legal label as a whole name
    for (int i = 0; i < apn_pkg::MAX_LABEL_DEF; i++) begin
      send_char(rand_char(), i == apn_pkg::MAX_LABEL_DEF - 1, 1'b0, NO_WANT);
    end
    // one byte too long in the middle of a name, then the item that ends it
    for (int i = 0; i <= apn_pkg::MAX_LABEL_DEF; i++) begin
      send_char(rand_char(), 1'b0, 1'b0, NO_WANT);
    end
    send_char(rand_char(), 1'b1, 1'b0, NO_WANT);
    names_sent += 2;

    // random names with noise bursts and an occasional full drain
    rand_base = items_counted;
    while (items_counted - rand_base < RAND_ITEMS) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 99) < 15) begin
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++) begin
          send_char(($urandom_range(0, 3) == 0) ? apn_pkg::DOT_CHAR : rand_char(),
                    ($urandom_range(0, 2) == 0), 1'b0, NO_WANT);
        end
      end else begin
        send_name(0);
      end
      if ($urandom_range(0, 14) == 0) hold_for_drain();
    end
    no_gaps = 1'b0;
    in_valid <= 1'b0;

    // wait for the tail, then keep watching for stray items
    waited = 0;
    @(posedge clk);
    while (expected_bytes.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_bytes.size());
      fail_count++;
    end

    $display("Run covered %0d names and %0d input items, labels up to %0d+1 bytes.",
             names_sent, items_counted, apn_pkg::MAX_LABEL_DEF);
    $display("Checked %0d result items, %0d of them error items; %0d mismatches.",
             results_seen, errors_seen, fail_count);
    if (fail_count == 0) begin
      $display("** apn_label_encoder: PASSED **");
    end else begin
      $display("** apn_label_encoder: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/apn_pkg.sv
design/apn_ram.sv
design/apn_label_encoder.sv
dv/testbench.sv
